>>> design/cwst_pkg.sv
// Shared types and constants for the counter wait slot table.
package cwst_pkg;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned SLOT_W       = $clog2(SLOTS);
  localparam int unsigned SLOT_FIELD_W = 4;
  localparam int unsigned MAX_RESULTS  = 16;
  localparam int unsigned CNT_W        = $clog2(MAX_RESULTS);
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    CMD_ADD    = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_WAIT     = 2'd0,
    KIND_READY    = 2'd1,
    KIND_FULL     = 2'd2,
    KIND_RELEASED = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    OP_ADD    = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } bk_state_e;

  typedef struct packed {
    cmd_e        command;
    logic [15:0] fiber_index;
    logic [31:0] target_value;
    logic [15:0] flag_handle;
    logic [7:0]  pinned_thread;
    logic [31:0] new_value;
  } in_item_t;

  typedef struct packed {
    kind_e                   kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [15:0]             out_fiber;
    logic [15:0]             out_flag;
    logic [7:0]              out_pinned;
    logic                    last;
  } out_item_t;

  // Classified queue entry: the compare key is the target for an add and
  // the new counter value for an update.
  typedef struct packed {
    op_e         op;
    logic [31:0] key;
    logic [15:0] fiber;
    logic [15:0] flag;
    logic [7:0]  pin;
  } q_entry_t;

endpackage

>>> design/counter_wait_slot_table.sv
// Top level of the counter wait slot table.
//
// Usage
//   in_*  : valid/ready channel of in_item_t. An add item takes the lowest free
//           slot; an update item loads the counter and releases matching slots.
//   out_* : valid/ready channel of out_item_t. One result per add (waiting,
//           ready now or table full); one released result per matching slot
//           of an update, last set on the final one, none if nothing matches.
//   cfg_* : write enable and data; loads the counter value at once. Write it
//           only while the block is idle.
// Flow
//   An add's result is loaded into the result register once the item has left
//   the front queue; an update loads its match vector as it is taken, then
//   gives its releases from the scan state through the result register. The
//   back end takes a new add whenever the result register is free, and no item during a scan.
// Reset
//   All slots free, counter 0, queue empty, no result pending.
// Stall
//   A stalled receiver holds the result register; the back end waits and the
//   front queue keeps taking items until both entries are full.
module counter_wait_slot_table import cwst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  logic     q_valid;
  logic     q_ready;
  q_entry_t q_entry;

  // classify and queue
  cwst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_entry_o  (q_entry)
  );

  // table, counter and release scan
  cwst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_entry_i   (q_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A full front queue always offers an item to the back end.
  a_full_queue_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("front queue full but nothing offered");

  // Only released results may be non-final.
  a_add_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind != KIND_RELEASED) |-> out_data_o.last)
    else $error("add result without last");

  // A table-full result names slot zero.
  a_full_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_FULL) |-> (out_data_o.slot == '0))
    else $error("table-full result with nonzero slot");

  // The back end never takes an item that is not offered.
  a_pop_when_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready |-> q_valid)
    else $error("queue popped while empty");

endmodule

>>> design/cwst_front.sv
// Front end: classifies input items and buffers them in a short queue.
module cwst_front import cwst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     q_valid_o,
  input  logic     q_ready_i,
  output q_entry_t q_entry_o
);

  q_entry_t          entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  q_entry_t          cls;
  logic              push, pop;

  always_comb begin
    cls.fiber = in_data_i.fiber_index;
    cls.flag  = in_data_i.flag_handle;
    cls.pin   = in_data_i.pinned_thread;
    unique case (in_data_i.command)
      CMD_ADD: begin
        cls.op  = OP_ADD;
        cls.key = in_data_i.target_value;
      end
      default: begin
        cls.op  = OP_UPDATE;
        cls.key = in_data_i.new_value;
      end
    endcase
  end

  assign in_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_entry_o  = entries_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= cls;
    end
  end

endmodule

>>> design/cwst_back.sv
// Back end: slot table, counter value, release scan and result register.
module cwst_back import cwst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  q_entry_t    q_entry_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  bk_state_e         state_q, state_d;
  logic [SLOTS-1:0]  busy_q, busy_d;
  logic [SLOTS-1:0]  pending_q, pending_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [31:0]       cur_val_q, cur_val_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [31:0]       target_q [SLOTS];
  logic [15:0]       fiber_q  [SLOTS];
  logic [15:0]       flag_q   [SLOTS];
  logic [7:0]        pin_q    [SLOTS];

  logic              out_free;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] pend_idx;
  logic [SLOTS-1:0]  pend_rest;
  logic [SLOTS-1:0]  match_vec;
  logic              wr_en;
  logic              rel_last;

  assign out_free = !out_valid_q || out_ready_i;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // lowest pending release
  always_comb begin
    pend_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pending_q[i]) begin
        pend_idx = SLOT_W'(i);
      end
    end
    pend_rest           = pending_q;
    pend_rest[pend_idx] = 1'b0;
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = busy_q[i] && (target_q[i] == q_entry_i.key);
    end
  end

  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    pending_d   = pending_q;
    cnt_d       = cnt_q;
    cur_val_d   = cur_val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    q_ready_o   = 1'b0;
    wr_en       = 1'b0;
    rel_last    = 1'b0;
    if (cfg_we_i) begin
      cur_val_d = cfg_wdata_i;
    end
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i && out_free) begin
          q_ready_o = 1'b1;
          if (q_entry_i.op == OP_ADD) begin
            out_valid_d      = 1'b1;
            out_d.out_fiber  = q_entry_i.fiber;
            out_d.out_flag   = q_entry_i.flag;
            out_d.out_pinned = q_entry_i.pin;
            out_d.last       = 1'b1;
            if (!free_found) begin
              out_d.kind = KIND_FULL;
              out_d.slot = '0;
            end else begin
              wr_en      = 1'b1;
              out_d.slot = SLOT_FIELD_W'(free_idx);
              if (q_entry_i.key == cur_val_q) begin
                out_d.kind = KIND_READY;
              end else begin
                out_d.kind       = KIND_WAIT;
                busy_d[free_idx] = 1'b1;
              end
            end
          end else begin
            cur_val_d = q_entry_i.key;
            pending_d = match_vec;
            cnt_d     = '0;
            state_d   = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (pending_q == '0) begin
          state_d = BK_IDLE;
        end else if (out_free) begin
          rel_last         = (pend_rest == '0) || (cnt_q == CNT_W'(MAX_RESULTS - 1));
          out_valid_d      = 1'b1;
          out_d.kind       = KIND_RELEASED;
          out_d.slot       = SLOT_FIELD_W'(pend_idx);
          out_d.out_fiber  = fiber_q[pend_idx];
          out_d.out_flag   = flag_q[pend_idx];
          out_d.out_pinned = pin_q[pend_idx];
          out_d.last       = rel_last;
          busy_d[pend_idx] = 1'b0;
          pending_d        = pend_rest;
          cnt_d            = cnt_q + CNT_W'(1);
          if (rel_last) begin
            pending_d = '0;
            state_d   = BK_IDLE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      busy_q      <= '0;
      pending_q   <= '0;
      cnt_q       <= '0;
      cur_val_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      pending_q   <= pending_d;
      cnt_q       <= cnt_d;
      cur_val_q   <= cur_val_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (wr_en) begin
      target_q[free_idx] <= q_entry_i.key;
      fiber_q[free_idx]  <= q_entry_i.fiber;
      flag_q[free_idx]   <= q_entry_i.flag;
      pin_q[free_idx]    <= q_entry_i.pin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> test/counter_wait_slot_table_test.sv
// Self-checking testbench for the counter wait slot table: directed rows, then random phases.
`timescale 1ns / 1ps

module counter_wait_slot_table_test;
  import cwst_pkg::*;

  localparam int QUIET_LIMIT  = 3000; // cycles with no item moving on either side
  localparam int RX_HOLD      = 400;  // long receiver hold-off, well under the limit
  localparam int DRAIN_CYCLES = 12;   // covers a no-match update still in the back end
  localparam int END_CYCLES   = 20;

  // One row of the directed table. Where typed is set, the result is written out
  // by hand: kind and slot here, the rest echoes the request, last set.
  typedef struct {
    cmd_e        cmd;
    logic [15:0] fiber;
    logic [31:0] target;
    logic [15:0] flag;
    logic [7:0]  pin;
    logic [31:0] nv;
    bit          typed;
    kind_e       kind;
    logic [3:0]  slot;
  } step_row_t;

  // One random phase: counter value loaded first, idling on each side, mix of
  // adds and updates, and the pressure tricks it carries.
  typedef struct {
    logic [31:0] start_value;
    int          tx_max;
    int          rx_max;
    int          add_pct;
    int          n_items;
    bit          long_hold;
    bit          mid_pause;
  } phase_t;

  logic      clk;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  // Predictor state: own copy of the slot table and the counter.
  bit          slot_taken  [SLOTS];
  logic [31:0] slot_goal   [SLOTS];
  logic [15:0] slot_fiber  [SLOTS];
  logic [15:0] slot_flag   [SLOTS];
  logic [7:0]  slot_pin    [SLOTS];
  logic [31:0] counter_now;

  out_item_t due_results [$];   // results still owed by the block, oldest first
  int        failures;
  int        quiet_cycles;
  int        tx_gap_max;
  int        rx_stall_max;
  int        rx_stall_left;
  bit        rx_hold_req;

  // Counter starts at 0. Slots 1..15 are filled with targets 5, 7, 9
  // and a few odd values, so the updates below release groups of them.
  step_row_t directed_rows [25] = '{
    '{CMD_ADD,    16'h0000, 32'h0000_0000, 16'h0000, 8'h00, 32'h0000_0000,
      1'b1, KIND_READY, 4'd0},   // target equals counter: ready now
    '{CMD_ADD,    16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
      1'b1, KIND_WAIT, 4'd0},    // all-ones add waits in slot 0
    '{CMD_ADD,    16'h0011, 32'd5,         16'h0101, 8'h03, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h0012, 32'd7,         16'h0102, 8'hFF, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h0013, 32'd5,         16'h0103, 8'h01, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h0014, 32'd9,         16'h0104, 8'h7F, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h0015, 32'd7,         16'h0105, 8'h80, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h0016, 32'd5,         16'h0106, 8'hFF, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h0017, 32'h0001_0000, 16'h0107, 8'h10, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h0018, 32'd7,         16'h0108, 8'h20, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h0019, 32'd5,         16'h0109, 8'hFF, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h001A, 32'h8000_0000, 16'h010A, 8'h04, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h001B, 32'd7,         16'h010B, 8'h05, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h001C, 32'd9,         16'h010C, 8'h06, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h001D, 32'd5,         16'h010D, 8'hFF, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h001E, 32'h7FFF_FFFF, 16'h010E, 8'h08, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h001F, 32'd5,         16'h010F, 8'h09, 32'h0, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h1234, 32'd5,         16'hABCD, 8'h02, 32'h0,
      1'b1, KIND_FULL, 4'd0},    // every slot busy: table full, request echoed
    '{CMD_UPDATE, 16'h0000, 32'h0,         16'h0000, 8'h00, 32'd5, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_UPDATE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hDEAD_BEEF,
      1'b0, KIND_WAIT, 4'd0},    // nothing matches: no result at all
    '{CMD_UPDATE, 16'h0000, 32'h0,         16'h0000, 8'h00, 32'd7, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_UPDATE, 16'h0000, 32'h0,         16'h0000, 8'h00, 32'hFFFF_FFFF,
      1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h5A5A, 32'hFFFF_FFFF, 16'hA5A5, 8'hFF, 32'h0,
      1'b1, KIND_READY, 4'd0},   // slot 0 free again, target equals counter
    '{CMD_UPDATE, 16'h0000, 32'h0,         16'h0000, 8'h00, 32'd9, 1'b0, KIND_WAIT, 4'd0},
    '{CMD_ADD,    16'h0042, 32'd9,         16'h4242, 8'h00, 32'h0,
      1'b1, KIND_READY, 4'd0}
  };

  counter_wait_slot_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Predictor: applies one accepted item to the table copy and queues the
  // results it owes, in the order the block must give them.
  task automatic wait_table_step(input in_item_t it);
    int        i;
    int        n;
    out_item_t r;
    if (it.command == CMD_ADD) begin
      i = 0;
      while (i < SLOTS && slot_taken[i]) i++;
      r.out_fiber  = it.fiber_index;
      r.out_flag   = it.flag_handle;
      r.out_pinned = it.pinned_thread;
      r.last       = 1'b1;
      if (i == SLOTS) begin
        // table full leaves the state alone
        r.kind = KIND_FULL;
        r.slot = '0;
      end else begin
        slot_goal[i]  = it.target_value;
        slot_fiber[i] = it.fiber_index;
        slot_flag[i]  = it.flag_handle;
        slot_pin[i]   = it.pinned_thread;
        slot_taken[i] = (it.target_value != counter_now);
        r.kind = slot_taken[i] ? KIND_WAIT : KIND_READY;
        r.slot = 4'(i);
      end
      due_results.push_back(r);
    end else begin
      counter_now = it.new_value;
      n = 0;
      for (i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
        if (slot_taken[i] && slot_goal[i] == it.new_value) begin
          slot_taken[i] = 1'b0;
          r.kind       = KIND_RELEASED;
          r.slot       = 4'(i);
          r.out_fiber  = slot_fiber[i];
          r.out_flag   = slot_flag[i];
          r.out_pinned = slot_pin[i];
          r.last       = 1'b0;
          due_results.push_back(r);
          n++;
        end
      end
      if (n > 0) begin
        r = due_results.pop_back();
        r.last = 1'b1;
        due_results.push_back(r);
      end
    end
  endtask

  // Sender: random gap, then hold valid until the item is taken. Valid is left
  // high after acceptance so back-to-back items need no low cycle.
  task automatic offer(input in_item_t it, input bit typed, input out_item_t fixed);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk); while (!in_ready_o);
    wait_table_step(it);
    if (typed) begin
      void'(due_results.pop_back());
      due_results.push_back(fixed);
    end
  endtask

  // Loads the counter only once the block has gone quiet.
  task automatic load_counter(input logic [31:0] value);
    @(negedge clk);
    in_valid_i <= 1'b0;
    wait (due_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk);
    cfg_we_i    <= 1'b0;
    counter_now = value;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // Receiver: ready dropped for the stall drawn at the last acceptance, or for
  // the long hold-off when one is asked for.
  initial begin
    out_ready_i   = 1'b0;
    rx_stall_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req   = 1'b0;
        rx_stall_left = RX_HOLD;
      end
      if (rx_stall_left > 0) begin
        out_ready_i <= 1'b0;
        rx_stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result checker, field by field against the oldest owed result.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rx_stall_left = $urandom_range(0, rx_stall_max);
      if (due_results.size() == 0) begin
        $error("result with none owed: kind %0d slot %0d fiber %0h",
               out_data_o.kind, out_data_o.slot, out_data_o.out_fiber);
        failures++;
      end else begin
        want = due_results.pop_front();
        check_field("kind",       32'(want.kind),  32'(out_data_o.kind));
        check_field("slot",       32'(want.slot),  32'(out_data_o.slot));
        check_field("out_fiber",  32'(want.out_fiber),  32'(out_data_o.out_fiber));
        check_field("out_flag",   32'(want.out_flag),   32'(out_data_o.out_flag));
        check_field("out_pinned", 32'(want.out_pinned), 32'(out_data_o.out_pinned));
        check_field("last",       32'(want.last),  32'(out_data_o.last));
      end
    end
  end

  // Watchdog: nothing moving on either side for too long ends the run.
  always @(posedge clk) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("counter_wait_slot_table_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    phase_t      plan [5];
    in_item_t    it;
    out_item_t   fixed;
    logic [31:0] base;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    failures     = 0;
    quiet_cycles = 0;
    rx_hold_req  = 1'b0;
    tx_gap_max   = 18;
    rx_stall_max = 18;
    counter_now  = '0;
    foreach (slot_taken[s]) slot_taken[s] = 1'b0;

    // Phases: extremes of the counter, idling on and off per side, an
    // add-heavy phase that runs the table full, plus the two pressure tricks.
    plan[0] = '{32'hFFFF_FFFF, 18, 18, 70, 25, 1'b0, 1'b0};
    plan[1] = '{$urandom(),     0,  0, 85, 25, 1'b1, 1'b0};
    plan[2] = '{32'h0000_0000, 18,  0, 60, 25, 1'b0, 1'b1};
    plan[3] = '{32'h8000_0000,  0, 18, 75, 25, 1'b0, 1'b0};
    plan[4] = '{$urandom(),    18, 18, 65, 25, 1'b0, 1'b0};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    load_counter(32'h0000_0000);

    foreach (directed_rows[k]) begin
      it.command       = directed_rows[k].cmd;
      it.fiber_index   = directed_rows[k].fiber;
      it.target_value  = directed_rows[k].target;
      it.flag_handle   = directed_rows[k].flag;
      it.pinned_thread = directed_rows[k].pin;
      it.new_value     = directed_rows[k].nv;
      fixed.kind       = directed_rows[k].kind;
      fixed.slot       = directed_rows[k].slot;
      fixed.out_fiber  = directed_rows[k].fiber;
      fixed.out_flag   = directed_rows[k].flag;
      fixed.out_pinned = directed_rows[k].pin;
      fixed.last       = 1'b1;
      offer(it, directed_rows[k].typed, fixed);
    end

    foreach (plan[p]) begin
      load_counter(plan[p].start_value);
      base         = plan[p].start_value;
      tx_gap_max   = plan[p].tx_max;
      rx_stall_max = plan[p].rx_max;
      if (plan[p].long_hold) begin
        // receiver goes dark while the sender keeps offering back to back
        @(posedge clk);
        rx_hold_req = 1'b1;
      end
      for (int k = 0; k < plan[p].n_items; k++) begin
        if (plan[p].mid_pause && k == plan[p].n_items / 2) begin
          @(negedge clk);
          in_valid_i <= 1'b0;
          wait (due_results.size() == 0);
        end
        // Keys mostly near the phase base so adds hit the counter and updates
        // hit stored targets; the odd one is fully random.
        it.command       = ($urandom_range(0, 99) < plan[p].add_pct) ? CMD_ADD : CMD_UPDATE;
        it.fiber_index   = 16'($urandom());
        it.flag_handle   = 16'($urandom());
        it.pinned_thread = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom());
        it.target_value  = ($urandom_range(0, 7) == 0) ? $urandom()
                                                       : base + $urandom_range(0, 3);
        it.new_value     = ($urandom_range(0, 7) == 0) ? $urandom()
                                                       : base + $urandom_range(0, 3);
        offer(it, 1'b0, fixed);
      end
    end

    @(negedge clk);
    in_valid_i <= 1'b0;
    wait (due_results.size() == 0);
    repeat (END_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("counter_wait_slot_table_test OK");
    end else begin
      $display("counter_wait_slot_table_test NOT OK");
    end
    $finish;
  end

endmodule
